FILE: rtl/color_freq_calibrate_to_hsv_top_defines.svh
// Assertion macros for the colour calibration and HSV top level.
// Depends on a clock named clk and a reset named rst in the using module.
`ifndef COLOR_FREQ_CALIBRATE_TO_HSV_TOP_DEFINES_SVH
`define COLOR_FREQ_CALIBRATE_TO_HSV_TOP_DEFINES_SVH

// Condition implies consequence in the same cycle
`define CFH_ASSERT_IMPL(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("cfh assertion failed");

// Condition implies consequence in the next cycle
`define CFH_ASSERT_NEXT(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("cfh assertion failed");

`endif

FILE: rtl/cfh_pkg.sv
// Shared types, constants and helpers for the colour calibration and HSV pipeline.
// No dependencies.
`default_nettype none
package cfh_pkg;

  localparam int FREQ_BITS  = 20;
  localparam int LEVEL_BITS = 8;
  localparam int IDX_BITS   = 3;

  // Configuration register indexes
  typedef enum logic [IDX_BITS-1:0] {
    REG_ENABLE  = 3'd0,
    REG_RED_A   = 3'd1,
    REG_RED_B   = 3'd2,
    REG_GREEN_A = 3'd3,
    REG_GREEN_B = 3'd4,
    REG_BLUE_A  = 3'd5,
    REG_BLUE_B  = 3'd6
  } cfg_reg_t;

  localparam logic [FREQ_BITS-1:0] RED_A_RESET   = FREQ_BITS'(9185);
  localparam logic [FREQ_BITS-1:0] RED_B_RESET   = FREQ_BITS'(37571);
  localparam logic [FREQ_BITS-1:0] GREEN_A_RESET = FREQ_BITS'(8430);
  localparam logic [FREQ_BITS-1:0] GREEN_B_RESET = FREQ_BITS'(28887);
  localparam logic [FREQ_BITS-1:0] BLUE_A_RESET  = FREQ_BITS'(9652);
  localparam logic [FREQ_BITS-1:0] BLUE_B_RESET  = FREQ_BITS'(36541);

  // Hue sector offset selection
  typedef enum logic [1:0] {
    K_ZERO  = 2'd0,
    K_GREEN = 2'd1,
    K_BLUE  = 2'd2,
    K_WRAP  = 2'd3
  } sector_t;

  typedef struct packed {
    logic [FREQ_BITS-1:0] red_freq;
    logic [FREQ_BITS-1:0] green_freq;
    logic [FREQ_BITS-1:0] blue_freq;
  } in_t;

  typedef struct packed {
    logic [7:0]  red_level;
    logic [7:0]  green_level;
    logic [7:0]  blue_level;
    logic [15:0] hue_centideg;
    logic [13:0] sat_centipct;
    logic [13:0] val_centipct;
  } out_t;

  // One restoring division step: returns {quotient bit, new remainder}
  function automatic logic [8:0] div_step(input logic [7:0] rem, input logic nbit,
                                          input logic [7:0] den);
    logic [8:0] t;
    t = {rem, nbit};
    if (t >= {1'b0, den}) begin
      div_step = {1'b1, 8'(t - {1'b0, den})};
    end else begin
      div_step = {1'b0, t[7:0]};
    end
  endfunction

endpackage
`default_nettype wire

FILE: rtl/color_freq_calibrate_to_hsv_top.sv
// Top level: configuration registers, valid/stall pipeline control, HSV front end.
// Depends on cfh_pkg, cfh_cal, cfh_hdiv and the shared assertion macro header.
//
//   Port group  Direction  Transfer condition
//   in_*        input      in_valid high and in_stall low
//   out_*       output     out_valid high and out_stall low
//   cfg_*       input      cfg_we high
//
// One item enters every cycle while the pipe flows.
// Stages: 1 prep, 4 calibration divide, 1 max/min, 1 numerators, 4 HSV divide.
// Each stage advances when empty or when the next stage advances, so bubbles close up.
// Reset clears valid bits and loads the default enable and bounds.
// While enable is clear, transfers are taken and dropped.
`default_nettype none
`include "color_freq_calibrate_to_hsv_top_defines.svh"
module color_freq_calibrate_to_hsv_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  cfh_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output cfh_pkg::out_t                  out_data,
  input  logic                           cfg_we,
  input  logic [cfh_pkg::IDX_BITS-1:0]   cfg_index,
  input  logic [cfh_pkg::FREQ_BITS-1:0]  cfg_data
);
  localparam int FB = cfh_pkg::FREQ_BITS;

  logic          enable;
  logic [FB-1:0] red_a, red_b, green_a, green_b, blue_a, blue_b;
  logic [10:0]   v, en;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      enable  <= 1'b1;
      red_a   <= cfh_pkg::RED_A_RESET;
      red_b   <= cfh_pkg::RED_B_RESET;
      green_a <= cfh_pkg::GREEN_A_RESET;
      green_b <= cfh_pkg::GREEN_B_RESET;
      blue_a  <= cfh_pkg::BLUE_A_RESET;
      blue_b  <= cfh_pkg::BLUE_B_RESET;
    end else if (cfg_we) begin
      case (cfh_pkg::cfg_reg_t'(cfg_index))
        cfh_pkg::REG_ENABLE:  enable  <= cfg_data[0];
        cfh_pkg::REG_RED_A:   red_a   <= cfg_data;
        cfh_pkg::REG_RED_B:   red_b   <= cfg_data;
        cfh_pkg::REG_GREEN_A: green_a <= cfg_data;
        cfh_pkg::REG_GREEN_B: green_b <= cfg_data;
        cfh_pkg::REG_BLUE_A:  blue_a  <= cfg_data;
        cfh_pkg::REG_BLUE_B:  blue_b  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage advance chain
  always_comb begin
    en[10] = !v[10] || !out_stall;
    for (int i = 9; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign in_stall = !en[0];

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_valid && enable;
      end
      for (int i = 1; i < 11; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // Calibration per channel
  logic [7:0] rl, gl, bl;

  cfh_cal u_cal_r (.clk(clk), .en(en[4:0]), .freq(in_data.red_freq),
                   .bound_a(red_a), .bound_b(red_b), .level(rl));
  cfh_cal u_cal_g (.clk(clk), .en(en[4:0]), .freq(in_data.green_freq),
                   .bound_a(green_a), .bound_b(green_b), .level(gl));
  cfh_cal u_cal_b (.clk(clk), .en(en[4:0]), .freq(in_data.blue_freq),
                   .bound_a(blue_a), .bound_b(blue_b), .level(bl));

  // Max, min and hue sector
  logic [7:0]       cmax_c, cmin_c;
  logic signed [8:0] delta_c;
  cfh_pkg::sector_t k_c;

  always_comb begin
    cmax_c = rl;
    if (gl > cmax_c) cmax_c = gl;
    if (bl > cmax_c) cmax_c = bl;
    cmin_c = rl;
    if (gl < cmin_c) cmin_c = gl;
    if (bl < cmin_c) cmin_c = bl;
    if (cmax_c == rl) begin
      delta_c = $signed({1'b0, gl}) - $signed({1'b0, bl});
      k_c     = delta_c[8] ? cfh_pkg::K_WRAP : cfh_pkg::K_ZERO;
    end else if (cmax_c == gl) begin
      delta_c = $signed({1'b0, bl}) - $signed({1'b0, rl});
      k_c     = cfh_pkg::K_GREEN;
    end else begin
      delta_c = $signed({1'b0, rl}) - $signed({1'b0, gl});
      k_c     = cfh_pkg::K_BLUE;
    end
  end

  logic [23:0]       lev5;
  logic [7:0]        cmax5, diff5;
  logic signed [8:0] delta5;
  cfh_pkg::sector_t  k5;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      lev5   <= {rl, gl, bl};
      cmax5  <= cmax_c;
      diff5  <= cmax_c - cmin_c;
      delta5 <= delta_c;
      k5     <= k_c;
    end
  end

  // Numerators for hue, saturation and value
  logic [23:0]        kd;
  logic signed [24:0] dext, num_c;

  always_comb begin
    case (k5)
      cfh_pkg::K_ZERO:  kd = '0;
      cfh_pkg::K_GREEN: kd = 24'(diff5) * 24'd12000;
      cfh_pkg::K_BLUE:  kd = 24'(diff5) * 24'd24000;
      cfh_pkg::K_WRAP:  kd = 24'(diff5) * 24'd36000;
      default:          kd = '0;
    endcase
    dext  = {{16{delta5[8]}}, delta5};
    num_c = dext * 25'sd6000 + $signed({1'b0, kd});
  end

  logic [23:0] lev6, hnum6, snum6, vnum6;
  logic [7:0]  diff6, cmax6;
  logic        grey6, black6;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      lev6   <= lev5;
      hnum6  <= num_c[23:0];
      snum6  <= 24'(diff5) * 24'd10000;
      vnum6  <= 24'(cmax5) * 24'd10000;
      diff6  <= diff5;
      cmax6  <= cmax5;
      grey6  <= (diff5 == 8'd0);
      black6 <= (cmax5 == 8'd0);
    end
  end

  // HSV dividers
  logic [15:0] hq, sq, vq;

  cfh_hdiv u_div_h (.clk(clk), .en(en[10:7]), .dividend(hnum6), .divisor(diff6), .quot(hq));
  cfh_hdiv u_div_s (.clk(clk), .en(en[10:7]), .dividend(snum6), .divisor(cmax6), .quot(sq));
  cfh_hdiv u_div_v (.clk(clk), .en(en[10:7]), .dividend(vnum6), .divisor(8'd255), .quot(vq));

  // Carry levels and flags alongside the dividers
  logic [25:0] side [0:3];

  always_ff @(posedge clk) begin
    if (en[7]) begin
      side[0] <= {lev6, grey6, black6};
    end
    for (int j = 1; j < 4; j++) begin
      if (en[7+j]) begin
        side[j] <= side[j-1];
      end
    end
  end

  // Result
  always_comb begin
    out_data.red_level    = side[3][25:18];
    out_data.green_level  = side[3][17:10];
    out_data.blue_level   = side[3][9:2];
    out_data.hue_centideg = side[3][1] ? 16'd0 : hq;
    out_data.sat_centipct = side[3][0] ? 14'd0 : sq[13:0];
    out_data.val_centipct = vq[13:0];
  end

  assign out_valid = v[10];

  `CFH_ASSERT_NEXT(a_disabled_drop, in_valid && !in_stall && !enable, !v[0])
  `CFH_ASSERT_IMPL(a_hue_range, out_valid, out_data.hue_centideg < 16'd36000)
  `CFH_ASSERT_IMPL(a_sat_range, out_valid, out_data.sat_centipct <= 14'd10000)
  `CFH_ASSERT_IMPL(a_val_range, out_valid, out_data.val_centipct <= 14'd10000)

endmodule
`default_nettype wire

FILE: rtl/cfh_cal.sv
// One channel of frequency calibration: bound ordering, then an 8-bit restoring divide.
// Depends on cfh_pkg. Five register stages, two quotient bits per divide stage.
`default_nettype none
module cfh_cal (
  input  logic                          clk,
  input  logic [4:0]                    en,
  input  logic [cfh_pkg::FREQ_BITS-1:0] freq,
  input  logic [cfh_pkg::FREQ_BITS-1:0] bound_a,
  input  logic [cfh_pkg::FREQ_BITS-1:0] bound_b,
  output logic [7:0]                    level
);
  localparam int FB = cfh_pkg::FREQ_BITS;
  localparam int NB = FB + 8;

  logic [FB-1:0] lo, hi, d_c, n_c;
  logic          zero_c, full_c;
  logic [NB-1:0] num_c;

  logic [NB-1:0] num_s  [0:4];
  logic [FB-1:0] d_s    [0:4];
  logic [FB-1:0] r_s    [0:4];
  logic [7:0]    q_s    [0:4];
  logic          zero_s [0:4];
  logic          full_s [0:4];

  // Order the bounds and form numerator and divisor
  always_comb begin
    if (bound_a < bound_b) begin
      lo = bound_a;
      hi = bound_b;
    end else begin
      lo = bound_b;
      hi = bound_a;
    end
    if (bound_a == bound_b) begin
      zero_c = (freq <= FB'(1));
      full_c = 1'b0;
      d_c    = freq;
      n_c    = freq - FB'(1);
    end else begin
      zero_c = (freq <= lo);
      full_c = (freq >= hi);
      d_c    = hi - lo;
      n_c    = freq - lo;
    end
    num_c = {n_c, 8'b0} - {8'b0, n_c};
  end

  // Hold prepared operands
  always_ff @(posedge clk) begin
    if (en[0]) begin
      num_s[0]  <= num_c;
      d_s[0]    <= d_c;
      r_s[0]    <= num_c[NB-1:8];
      q_s[0]    <= '0;
      zero_s[0] <= zero_c;
      full_s[0] <= full_c;
    end
  end

  // Divide stages, two quotient bits each
  for (genvar j = 1; j < 5; j++) begin : g_div
    logic [FB:0]   t1, t2;
    logic [FB-1:0] r1, r2;
    logic          qa, qb;

    always_comb begin
      t1 = {r_s[j-1], num_s[j-1][9-2*j]};
      qa = (t1 >= {1'b0, d_s[j-1]});
      r1 = qa ? FB'(t1 - {1'b0, d_s[j-1]}) : t1[FB-1:0];
      t2 = {r1, num_s[j-1][8-2*j]};
      qb = (t2 >= {1'b0, d_s[j-1]});
      r2 = qb ? FB'(t2 - {1'b0, d_s[j-1]}) : t2[FB-1:0];
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        num_s[j]  <= num_s[j-1];
        d_s[j]    <= d_s[j-1];
        r_s[j]    <= r2;
        q_s[j]    <= {q_s[j-1][5:0], qa, qb};
        zero_s[j] <= zero_s[j-1];
        full_s[j] <= full_s[j-1];
      end
    end
  end

  // Clamp to the 8-bit range
  assign level = zero_s[4] ? 8'h00 : (full_s[4] ? 8'hFF : q_s[4]);

endmodule
`default_nettype wire

FILE: rtl/cfh_hdiv.sv
// 24-by-8 restoring divider giving a 16-bit quotient over four register stages.
// Depends on cfh_pkg (div_step). Four quotient bits per stage.
`default_nettype none
module cfh_hdiv (
  input  logic        clk,
  input  logic [3:0]  en,
  input  logic [23:0] dividend,
  input  logic [7:0]  divisor,
  output logic [15:0] quot
);
  logic [23:0] n_s [0:3];
  logic [7:0]  d_s [0:3];
  logic [7:0]  r_s [0:3];
  logic [15:0] q_s [0:3];

  for (genvar j = 0; j < 4; j++) begin : g_st
    logic [23:0] n_in;
    logic [7:0]  d_in, r_in, r_c;
    logic [15:0] q_in, q_c;
    logic [8:0]  st;

    if (j == 0) begin : g_first
      assign n_in = dividend;
      assign d_in = divisor;
      assign r_in = dividend[23:16];
      assign q_in = '0;
    end else begin : g_next
      assign n_in = n_s[j-1];
      assign d_in = d_s[j-1];
      assign r_in = r_s[j-1];
      assign q_in = q_s[j-1];
    end

    // Four dependent subtract steps
    always_comb begin
      r_c = r_in;
      q_c = q_in;
      st  = '0;
      for (int k = 0; k < 4; k++) begin
        st  = cfh_pkg::div_step(r_c, n_in[15-4*j-k], d_in);
        q_c = {q_c[14:0], st[8]};
        r_c = st[7:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        n_s[j] <= n_in;
        d_s[j] <= d_in;
        r_s[j] <= r_c;
        q_s[j] <= q_c;
      end
    end
  end

  assign quot = q_s[3];

endmodule
`default_nettype wire

FILE: tb/color_freq_calibrate_to_hsv_top_tb.sv
// Self-checking bench for the colour calibration and HSV pipeline: random and directed
// frequency triples, calibration bound changes and enable toggling, with stalls on both sides.
// Depends on cfh_pkg and color_freq_calibrate_to_hsv_top.
`default_nettype none
module color_freq_calibrate_to_hsv_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cfh_pkg::*;

  localparam int PIPE_DEPTH = 11;
  localparam logic [FREQ_BITS-1:0] FMAX = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [IDX_BITS-1:0] cfg_index = '0;
  logic [FREQ_BITS-1:0] cfg_data = '0;

  // Shadow copy of the block's registers
  logic cal_enable;
  logic [FREQ_BITS-1:0] bound_a [3];
  logic [FREQ_BITS-1:0] bound_b [3];

  out_t pending_hsv [$];
  int fail_count = 0;
  bit hold_off_req = 1'b0;
  bit noisy_sink = 1'b1;
  bit noisy_source = 1'b1;

  color_freq_calibrate_to_hsv_top u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Map one frequency onto 0..255 between two ordered bounds
  function automatic logic [7:0] calibrate_level(logic [FREQ_BITS-1:0] f,
                                                 logic [FREQ_BITS-1:0] a,
                                                 logic [FREQ_BITS-1:0] b);
    longint unsigned lo, hi, q;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (lo == hi) begin
      lo = 1;
      hi = longint'(f) + 1;
    end
    if (f <= lo) return 8'd0;
    q = ((longint'(f) - lo) * 255) / (hi - lo);
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function automatic out_t predict_hsv(in_t item);
    out_t res;
    longint r, g, b, cmax, cmin, diff, num;
    r = calibrate_level(item.red_freq, bound_a[0], bound_b[0]);
    g = calibrate_level(item.green_freq, bound_a[1], bound_b[1]);
    b = calibrate_level(item.blue_freq, bound_a[2], bound_b[2]);
    cmax = r;
    if (g > cmax) cmax = g;
    if (b > cmax) cmax = b;
    cmin = r;
    if (g < cmin) cmin = g;
    if (b < cmin) cmin = b;
    diff = cmax - cmin;
    res = '0;
    res.red_level = r[7:0];
    res.green_level = g[7:0];
    res.blue_level = b[7:0];
    if (diff > 0) begin
      if (cmax == r) num = 6000 * (g - b);
      else if (cmax == g) num = 6000 * (b - r) + 12000 * diff;
      else num = 6000 * (r - g) + 24000 * diff;
      if (num < 0) num += 36000 * diff;
      res.hue_centideg = 16'(num / diff);
    end
    if (cmax > 0) res.sat_centipct = 14'((10000 * diff) / cmax);
    res.val_centipct = 14'((10000 * cmax) / 255);
    return res;
  endfunction

  // Offer one item and hold it until the transfer
  task automatic send_freqs(logic [FREQ_BITS-1:0] r, logic [FREQ_BITS-1:0] g,
                            logic [FREQ_BITS-1:0] b);
    in_t item;
    int gap;
    item = '{red_freq: r, green_freq: g, blue_freq: b};
    if (noisy_source && $urandom_range(0, 3) == 0) begin
      gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    if (cal_enable) pending_hsv.push_back(predict_hsv(item));
    @(negedge clk);
  endtask

  task automatic drain_pipe();
    in_valid <= 1'b0;
    while (pending_hsv.size() != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 4) @(negedge clk);
  endtask

  // Registers change only once the pipe is empty
  task automatic write_reg(cfg_reg_t idx, logic [FREQ_BITS-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ENABLE:  cal_enable = value[0];
      REG_RED_A:   bound_a[0] = value;
      REG_RED_B:   bound_b[0] = value;
      REG_GREEN_A: bound_a[1] = value;
      REG_GREEN_B: bound_b[1] = value;
      REG_BLUE_A:  bound_a[2] = value;
      REG_BLUE_B:  bound_b[2] = value;
      default: ;
    endcase
  endtask

  task automatic set_bounds(logic [FREQ_BITS-1:0] ra, logic [FREQ_BITS-1:0] rb,
                            logic [FREQ_BITS-1:0] ga, logic [FREQ_BITS-1:0] gb,
                            logic [FREQ_BITS-1:0] ba, logic [FREQ_BITS-1:0] bb);
    drain_pipe();
    write_reg(REG_RED_A, ra);
    write_reg(REG_RED_B, rb);
    write_reg(REG_GREEN_A, ga);
    write_reg(REG_GREEN_B, gb);
    write_reg(REG_BLUE_A, ba);
    write_reg(REG_BLUE_B, bb);
  endtask

  // Frequency near the active bounds of one channel, or anywhere
  function automatic logic [FREQ_BITS-1:0] pick_freq(int ch);
    logic [FREQ_BITS-1:0] lo, hi;
    lo = (bound_a[ch] < bound_b[ch]) ? bound_a[ch] : bound_b[ch];
    hi = (bound_a[ch] < bound_b[ch]) ? bound_b[ch] : bound_a[ch];
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return FMAX - $urandom_range(0, 3);
      2: return $urandom_range(0, 3);
      default: begin
        if (hi - lo < 4 || $urandom_range(0, 4) == 0)
          return FREQ_BITS'($urandom_range(lo, hi) + $urandom_range(0, 8) - 4);
        return FREQ_BITS'($urandom_range(lo, hi));
      end
    endcase
  endfunction

  task automatic send_random(int count);
    repeat (count) send_freqs(pick_freq(0), pick_freq(1), pick_freq(2));
  endtask

  // Check each transfer out against the oldest prediction
  always @(posedge clk) begin
    out_t exp_hsv;
    if (!rst && out_valid && !out_stall) begin
      if (pending_hsv.size() == 0) begin
        $error("unexpected result %p", out_data);
        fail_count++;
      end else begin
        exp_hsv = pending_hsv.pop_front();
        if (out_data.red_level !== exp_hsv.red_level) begin
          $error("red_level exp %0d got %0d", exp_hsv.red_level, out_data.red_level);
          fail_count++;
        end
        if (out_data.green_level !== exp_hsv.green_level) begin
          $error("green_level exp %0d got %0d", exp_hsv.green_level, out_data.green_level);
          fail_count++;
        end
        if (out_data.blue_level !== exp_hsv.blue_level) begin
          $error("blue_level exp %0d got %0d", exp_hsv.blue_level, out_data.blue_level);
          fail_count++;
        end
        if (out_data.hue_centideg !== exp_hsv.hue_centideg) begin
          $error("hue_centideg exp %0d got %0d", exp_hsv.hue_centideg,
                 out_data.hue_centideg);
          fail_count++;
        end
        if (out_data.sat_centipct !== exp_hsv.sat_centipct) begin
          $error("sat_centipct exp %0d got %0d", exp_hsv.sat_centipct,
                 out_data.sat_centipct);
          fail_count++;
        end
        if (out_data.val_centipct !== exp_hsv.val_centipct) begin
          $error("val_centipct exp %0d got %0d", exp_hsv.val_centipct,
                 out_data.val_centipct);
          fail_count++;
        end
      end
    end
  end

  // Drive the receiver stall: random gaps, or a long counted hold-off on request
  always @(negedge clk) begin
    int stall_left;
    if (hold_off_req) begin
      out_stall <= 1'b1;
      for (stall_left = 60; stall_left > 0; stall_left--) @(negedge clk);
      hold_off_req = 1'b0;
      out_stall <= 1'b0;
    end else if (noisy_sink && $urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
      repeat (stall_left) @(negedge clk);
      out_stall <= 1'b0;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Field extremes, grey, black, hue sectors, wrap and equal bounds
  task automatic test_directed();
    send_freqs('0, '0, '0);
    send_freqs(FMAX, FMAX, FMAX);
    send_freqs(37571, 8430, 9652);
    send_freqs(37571, 28887, 9652);
    send_freqs(9185, 28887, 9652);
    send_freqs(9185, 28887, 36541);
    send_freqs(9185, 8430, 36541);
    send_freqs(37571, 8430, 20000);
    send_freqs(37571, 28887, 36541);
    send_freqs(20000, 15000, 30000);
    send_freqs(9184, 8429, 9651);
    send_freqs(9186, 8431, 9653);
    send_freqs(FMAX, '0, 20000);
    send_freqs(23378, 18658, 23096);
    set_bounds(5000, 5000, '0, '0, FMAX, FMAX);
    send_freqs('0, '0, '0);
    send_freqs(1, 1, 1);
    send_freqs(2, 7, FMAX);
    send_freqs(FMAX, 5000, 3);
    set_bounds(FMAX, '0, 20000, 10, '0, 1);
    send_freqs(FMAX - 1, 20000, '0);
    send_freqs(1, 19999, 2);
    send_freqs(FREQ_BITS'(20'h55555), FREQ_BITS'(20'hAAAAA), FREQ_BITS'(20'h55555));
  endtask

  task automatic test_random_bounds();
    int phase;
    set_bounds(RED_A_RESET, RED_B_RESET, GREEN_A_RESET, GREEN_B_RESET,
               BLUE_A_RESET, BLUE_B_RESET);
    send_random(250);
    for (phase = 0; phase < 5; phase++) begin
      set_bounds($urandom(), $urandom(), $urandom_range(0, 300), $urandom_range(0, 300),
                 $urandom_range(1000, 3000), $urandom_range(1000, 3000));
      send_random(60);
    end
  endtask

  // Disabled items must vanish; enable again afterwards
  task automatic test_enable();
    drain_pipe();
    write_reg(REG_ENABLE, '0);
    send_random(30);
    drain_pipe();
    write_reg(REG_ENABLE, 20'd1);
    send_random(30);
  endtask

  // Fill the pipe against a held receiver, then pause until it drains
  task automatic test_backpressure();
    noisy_source = 1'b0;
    hold_off_req = 1'b1;
    send_random(40);
    in_valid <= 1'b0;
    while (pending_hsv.size() != 0) @(negedge clk);
    noisy_sink = 1'b0;
    send_random(60);
    noisy_sink = 1'b1;
    noisy_source = 1'b1;
    send_random(60);
  endtask

  initial begin
    cal_enable = 1'b1;
    bound_a = '{RED_A_RESET, GREEN_A_RESET, BLUE_A_RESET};
    bound_b = '{RED_B_RESET, GREEN_B_RESET, BLUE_B_RESET};
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_random_bounds();
    test_enable();
    test_backpressure();
    drain_pipe();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
`default_nettype wire
